### design/l2_ingress_frame_classifier_core_assert.svh
// Assertion macros for the ingress frame classifier.
// Used by the top level; needs clk and rst_n in scope.
`ifndef L2_INGRESS_FRAME_CLASSIFIER_CORE_ASSERT_SVH
`define L2_INGRESS_FRAME_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define L2IFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("l2ifc: same-cycle check failed");

// next-cycle implication
`define L2IFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("l2ifc: next-cycle check failed");

`endif

### design/l2ifc_pkg.sv
// Types and constants for the ingress frame classifier.
// No dependencies.
package l2ifc_pkg;

  localparam int MAC_W   = 48;
  localparam int ETYPE_W = 16;
  localparam int VID_W   = 12;
  localparam int LEN_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [MAC_W-1:0]   MAC_BCAST  = '1;
  localparam logic [ETYPE_W-1:0] ETYPE_VLAN = 16'h8100;
  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0]        ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0]        ARP_OP_REPLY   = 16'd2;
  localparam logic [LEN_W-1:0]   ETH_OVERHEAD   = 16'd18;

  localparam logic [1:0] L2_UNKNOWN  = 2'd0;
  localparam logic [1:0] L2_ACCESS   = 2'd1;
  localparam logic [1:0] L2_TRUNK    = 2'd2;
  localparam logic [1:0] L2_RESERVED = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IF_MAC     = 4'd0,
    CFG_L3_ENABLED = 4'd1,
    CFG_L2_MODE    = 4'd2,
    CFG_VLAN_COUNT = 4'd3,
    CFG_VLAN_0     = 4'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DISP_DROP    = 3'd0,
    DISP_IPV4    = 3'd1,
    DISP_ARP_REQ = 3'd2,
    DISP_ARP_REP = 3'd3,
    DISP_SWITCH  = 3'd4
  } disp_t;

  typedef enum logic [3:0] {
    RSN_NONE          = 4'd0,
    RSN_TAGGED_L3     = 4'd1,
    RSN_NOT_ADDRESSED = 4'd2,
    RSN_ACCESS_NO_VID = 4'd3,
    RSN_TAGGED_ACCESS = 4'd4,
    RSN_UNTAGGED_TRNK = 4'd5,
    RSN_VID_DENIED    = 4'd6,
    RSN_UNKNOWN_TYPE  = 4'd7,
    RSN_UNKNOWN_ARPOP = 4'd8
  } reason_t;

  typedef struct packed {
    logic [MAC_W-1:0] if_mac;
    logic             l3_enabled;
    logic [1:0]       l2_mode;
    logic [2:0]       vlan_count;
  } cfg_t;

  typedef struct packed {
    logic             has_tag;
    logic             addr_ok;
    logic             is_ipv4;
    logic             is_arp;
    logic             op_req;
    logic             op_rep;
    logic             vlan_hit;
    logic [VID_W-1:0] vid;
    logic [LEN_W-1:0] plen;
  } flags_t;

  typedef struct packed {
    disp_t            disp;
    reason_t          reason;
    logic             need_tag;
    logic [VID_W-1:0] vlan;
    logic [LEN_W-1:0] plen;
  } result_t;

endpackage

### design/l2ifc_cfg_regs.sv
// Configuration register file of the ingress frame classifier.
// Depends on l2ifc_pkg.
module l2ifc_cfg_regs #(
  parameter int VLAN_SLOTS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [l2ifc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [l2ifc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output l2ifc_pkg::cfg_t                      cfg,
  output logic [VLAN_SLOTS-1:0][l2ifc_pkg::VID_W-1:0] vlans
);
  import l2ifc_pkg::*;

  cfg_t                            cfg_r;
  logic [VLAN_SLOTS-1:0][VID_W-1:0] vlans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      vlans_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IF_MAC:     cfg_r.if_mac     <= cfg_data[MAC_W-1:0];
        CFG_L3_ENABLED: cfg_r.l3_enabled <= cfg_data[0];
        CFG_L2_MODE:    cfg_r.l2_mode    <= cfg_data[1:0];
        CFG_VLAN_COUNT: cfg_r.vlan_count <= cfg_data[2:0];
        default: begin
          for (int i = 0; i < VLAN_SLOTS; i++) begin
            if (cfg_index == CFG_IDX_W'(CFG_VLAN_0 + i)) begin
              vlans_r[i] <= cfg_data[VID_W-1:0];
            end
          end
        end
      endcase
    end
  end

  assign cfg   = cfg_r;
  assign vlans = vlans_r;

endmodule

### design/l2_ingress_frame_classifier_core.sv
// Ingress frame classifier top level: three-stage header pipeline.
// Depends on l2ifc_pkg, l2ifc_cfg_regs and the assertion macro header.
//
// Takes one frame header per beat and returns one classification per header,
// in order, from the stage-three output register. Unless the output stalls,
// a new header is taken every cycle: stage one does the address, ethertype,
// VLAN slot and length compares, stage two picks disposition and drop reason,
// stage three is the output register. Each stage holds its own valid bit, so
// backpressure fills bubbles first and never drops or repeats a beat.
// Configuration writes are taken every cycle (cfg_ready is tied high) and are
// meant to land while no header is in flight.
module l2_ingress_frame_classifier_core #(
  parameter int VLAN_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // dest_mac, ether_type, frame_vlan, arp_opcode, frame_length, pad
  input  logic [111:0]                        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drop_reason, need_tag, out_vlan, payload_length, pad
  output logic [39:0]                         out_tdata,
  // disposition, pad
  output logic [7:0]                          out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [l2ifc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [l2ifc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import l2ifc_pkg::*;

  cfg_t                             cfg;
  logic [VLAN_SLOTS-1:0][VID_W-1:0] vlans;

  l2ifc_cfg_regs #(.VLAN_SLOTS(VLAN_SLOTS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .vlans     (vlans)
  );

  assign cfg_ready = 1'b1;

  logic [MAC_W-1:0]   dest_mac;
  logic [ETYPE_W-1:0] ether_type;
  logic [VID_W-1:0]   frame_vlan;
  logic [15:0]        arp_opcode;
  logic [LEN_W-1:0]   frame_length;

  assign dest_mac     = in_tdata[47:0];
  assign ether_type   = in_tdata[63:48];
  assign frame_vlan   = in_tdata[75:64];
  assign arp_opcode   = in_tdata[91:76];
  assign frame_length = in_tdata[107:92];

  logic    v1_r, v2_r, v3_r;
  logic    rdy1, rdy2, rdy3;
  flags_t  s1_r, s1_nxt;
  result_t s2_r, s2_nxt;
  result_t s3_r;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // stage 1: compares
  always_comb begin
    s1_nxt          = '0;
    s1_nxt.has_tag  = (ether_type == ETYPE_VLAN);
    s1_nxt.addr_ok  = (dest_mac == cfg.if_mac) || (dest_mac == MAC_BCAST);
    s1_nxt.is_ipv4  = (ether_type == ETYPE_IPV4);
    s1_nxt.is_arp   = (ether_type == ETYPE_ARP);
    s1_nxt.op_req   = (arp_opcode == ARP_OP_REQUEST);
    s1_nxt.op_rep   = (arp_opcode == ARP_OP_REPLY);
    s1_nxt.vid      = frame_vlan;
    s1_nxt.plen     = (frame_length > ETH_OVERHEAD) ? frame_length - ETH_OVERHEAD : '0;
    for (int i = 0; i < VLAN_SLOTS; i++) begin
      if ((vlans[i] == frame_vlan) && (cfg.vlan_count > 3'(i))) begin
        s1_nxt.vlan_hit = 1'b1;
      end
    end
  end

  // stage 2: decision
  always_comb begin
    s2_nxt        = '0;
    s2_nxt.disp   = DISP_DROP;
    s2_nxt.reason = RSN_NONE;
    if (cfg.l3_enabled) begin
      if (s1_r.has_tag) begin
        s2_nxt.reason = RSN_TAGGED_L3;
      end else if (!s1_r.addr_ok) begin
        s2_nxt.reason = RSN_NOT_ADDRESSED;
      end else if (s1_r.is_ipv4) begin
        s2_nxt.disp = DISP_IPV4;
        s2_nxt.plen = s1_r.plen;
      end else if (s1_r.is_arp) begin
        if (s1_r.op_req) begin
          s2_nxt.disp = DISP_ARP_REQ;
        end else if (s1_r.op_rep) begin
          s2_nxt.disp = DISP_ARP_REP;
        end else begin
          s2_nxt.reason = RSN_UNKNOWN_ARPOP;
        end
      end else begin
        s2_nxt.reason = RSN_UNKNOWN_TYPE;
      end
    end else begin
      case (cfg.l2_mode)
        L2_ACCESS: begin
          if (cfg.vlan_count == '0) begin
            s2_nxt.reason = RSN_ACCESS_NO_VID;
          end else if (s1_r.has_tag) begin
            s2_nxt.reason = RSN_TAGGED_ACCESS;
          end else begin
            s2_nxt.disp     = DISP_SWITCH;
            s2_nxt.need_tag = 1'b1;
            s2_nxt.vlan     = vlans[0];
          end
        end
        L2_TRUNK: begin
          if (!s1_r.has_tag) begin
            s2_nxt.reason = RSN_UNTAGGED_TRNK;
          end else if (s1_r.vlan_hit) begin
            s2_nxt.disp = DISP_SWITCH;
            s2_nxt.vlan = s1_r.vid;
          end else begin
            s2_nxt.reason = RSN_VID_DENIED;
          end
        end
        default: s2_nxt.reason = RSN_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)      s2_r <= s2_nxt;
    if (rdy3 && v2_r)      s3_r <= s2_r;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'b0, s3_r.plen, s3_r.vlan, s3_r.need_tag, s3_r.reason};
  assign out_tuser  = {5'b0, s3_r.disp};

`include "l2_ingress_frame_classifier_core_assert.svh"

  `L2IFC_ASSERT_IMPL(a_drop_clean, out_tvalid && (out_tuser[2:0] == DISP_DROP), out_tdata[32:4] == '0)
  `L2IFC_ASSERT_IMPL(a_reason_drop, out_tvalid && (out_tdata[3:0] != RSN_NONE), out_tuser[2:0] == DISP_DROP)
  `L2IFC_ASSERT_IMPL(a_tag_switch, out_tvalid && out_tdata[4], out_tuser[2:0] == DISP_SWITCH)
  `L2IFC_ASSERT_NEXT(a_accept_fill, in_tvalid && in_tready, v1_r)

endmodule

### tb/sv/l2_ingress_frame_classifier_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the L2 ingress frame classifier: directed headers, then random ones
// under several register settings and stall patterns, checked against a built-in classifier.
// Depends on l2ifc_pkg and l2_ingress_frame_classifier_core.
module l2_ingress_frame_classifier_core_tb;
  import l2ifc_pkg::*;

  localparam int VLAN_SLOTS  = 4;
  localparam int HW_SLOTS    = 4;
  localparam int LATENCY     = 3;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BLOCK_ITEMS = 46;

  typedef struct packed {
    logic [MAC_W-1:0]   dmac;
    logic [ETYPE_W-1:0] etype;
    logic [VID_W-1:0]   vid;
    logic [15:0]        op;
    logic [LEN_W-1:0]   len;
  } frame_t;

  class frame_scoreboard;
    logic [MAC_W-1:0] mac;
    logic             l3;
    logic [1:0]       mode;
    logic [2:0]       count;
    logic [VID_W-1:0] vlans [HW_SLOTS];
    result_t          verdicts [$];
    int               errors;

    function new();
      mac = '0;
      l3 = 1'b0;
      mode = '0;
      count = '0;
      foreach (vlans[i]) vlans[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IF_MAC:     mac = data[MAC_W-1:0];
        CFG_L3_ENABLED: l3 = data[0];
        CFG_L2_MODE:    mode = data[1:0];
        CFG_VLAN_COUNT: count = data[2:0];
        default: begin
          if (idx >= CFG_VLAN_0 && idx < CFG_VLAN_0 + HW_SLOTS)
            vlans[idx - CFG_VLAN_0] = data[VID_W-1:0];
        end
      endcase
    endfunction

    function result_t classify(frame_t f);
      result_t r;
      logic    has_tag;
      logic    hit;
      int      n;
      r = '0;
      r.disp = DISP_DROP;
      r.reason = RSN_NONE;
      has_tag = (f.etype == ETYPE_VLAN);
      if (l3) begin
        if (has_tag) r.reason = RSN_TAGGED_L3;
        else if (f.dmac != mac && f.dmac != MAC_BCAST) r.reason = RSN_NOT_ADDRESSED;
        else if (f.etype == ETYPE_IPV4) begin
          r.disp = DISP_IPV4;
          r.plen = (f.len > ETH_OVERHEAD) ? f.len - ETH_OVERHEAD : '0;
        end else if (f.etype == ETYPE_ARP) begin
          if (f.op == ARP_OP_REQUEST) r.disp = DISP_ARP_REQ;
          else if (f.op == ARP_OP_REPLY) r.disp = DISP_ARP_REP;
          else r.reason = RSN_UNKNOWN_ARPOP;
        end else r.reason = RSN_UNKNOWN_TYPE;
      end else if (mode == L2_ACCESS) begin
        if (count == 0) r.reason = RSN_ACCESS_NO_VID;
        else if (has_tag) r.reason = RSN_TAGGED_ACCESS;
        else begin
          r.disp = DISP_SWITCH;
          r.need_tag = 1'b1;
          r.vlan = vlans[0];
        end
      end else if (mode == L2_TRUNK) begin
        // slot count saturates at the number of slots
        n = (count > VLAN_SLOTS) ? VLAN_SLOTS : count;
        hit = 1'b0;
        for (int i = 0; i < n; i++) if (vlans[i] == f.vid) hit = 1'b1;
        if (!has_tag) r.reason = RSN_UNTAGGED_TRNK;
        else if (hit) begin
          r.disp = DISP_SWITCH;
          r.vlan = f.vid;
        end else r.reason = RSN_VID_DENIED;
      end
      return r;
    endfunction

    function void note_frame(frame_t f);
      verdicts.push_back(classify(f));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: disp=%0d rsn=%0d tag=%0b vlan=%0d plen=%0d",
                   got.disp, got.reason, got.need_tag, got.vlan, got.plen);
        return;
      end
      want = verdicts.pop_front();
      if (want.disp !== got.disp || want.reason !== got.reason ||
          want.need_tag !== got.need_tag || want.vlan !== got.vlan ||
          want.plen !== got.plen) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp disp=%0d rsn=%0d tag=%0b vlan=%0d plen=%0d,",
                    " got disp=%0d rsn=%0d tag=%0b vlan=%0d plen=%0d"},
                   want.disp, want.reason, want.need_tag, want.vlan, want.plen,
                   got.disp, got.reason, got.need_tag, got.vlan, got.plen);
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [111:0]          in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;
  logic [7:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb = new();
  int snd_idle_pct = 9;
  int rcv_idle_pct = 63;
  int hold_reqs = 0;
  int cycles = 0;

  l2_ingress_frame_classifier_core #(.VLAN_SLOTS(VLAN_SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL l2_ingress_frame_classifier_core");
      $finish;
    end
  end

  // result beats, sampled at the rising edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.disp = disp_t'(out_tuser[2:0]);
      got.reason = reason_t'(out_tdata[3:0]);
      got.need_tag = out_tdata[4];
      got.vlan = out_tdata[16:5];
      got.plen = out_tdata[32:17];
      sb.check_result(got);
    end
  end

  // receiver: random ready, or a long hold-off on request
  initial begin : rx_drive
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic frame_t mk(logic [MAC_W-1:0] dmac, logic [ETYPE_W-1:0] etype,
                                logic [VID_W-1:0] vid, logic [15:0] op, logic [LEN_W-1:0] len);
    frame_t f;
    f.dmac = dmac;
    f.etype = etype;
    f.vid = vid;
    f.op = op;
    f.len = len;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) f.dmac = sb.mac;
    else if (sel < 6) f.dmac = MAC_BCAST;
    else if (sel == 6) f.dmac = '0;
    else f.dmac = rand48();
    sel = $urandom_range(9);
    if (sel < 3) f.etype = ETYPE_VLAN;
    else if (sel < 5) f.etype = ETYPE_IPV4;
    else if (sel < 7) f.etype = ETYPE_ARP;
    else if (sel == 7) f.etype = ETYPE_VLAN ^ (16'd1 << $urandom_range(15));
    else f.etype = ETYPE_W'($urandom);
    if ($urandom_range(9) < 6) f.vid = sb.vlans[$urandom_range(HW_SLOTS-1)];
    else f.vid = VID_W'($urandom);
    sel = $urandom_range(9);
    if (sel < 4) f.op = ARP_OP_REQUEST;
    else if (sel < 7) f.op = ARP_OP_REPLY;
    else f.op = 16'($urandom);
    if ($urandom_range(9) < 3) f.len = LEN_W'($urandom_range(40));
    else f.len = LEN_W'($urandom);
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, f.len, f.op, f.vid, f.etype, f.dmac};
    do @(posedge clk); while (!in_tready);
    sb.note_frame(f);
  endtask

  // stop offering and wait out every pending result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [MAC_W-1:0] mac, logic l3, logic [1:0] mode,
                            logic [2:0] count, logic [VID_W-1:0] v0, logic [VID_W-1:0] v1,
                            logic [VID_W-1:0] v2, logic [VID_W-1:0] v3);
    drain();
    cfg_write(CFG_IF_MAC, mac);
    cfg_write(CFG_L3_ENABLED, CFG_DATA_W'(l3));
    cfg_write(CFG_L2_MODE, CFG_DATA_W'(mode));
    cfg_write(CFG_VLAN_COUNT, CFG_DATA_W'(count));
    cfg_write(CFG_VLAN_0, CFG_DATA_W'(v0));
    cfg_write(CFG_IDX_W'(CFG_VLAN_0 + 1), CFG_DATA_W'(v1));
    cfg_write(CFG_IDX_W'(CFG_VLAN_0 + 2), CFG_DATA_W'(v2));
    cfg_write(CFG_IDX_W'(CFG_VLAN_0 + 3), CFG_DATA_W'(v3));
    cfg_release();
  endtask

  // upper data bits are random on purpose: only the register width counts
  task automatic random_config();
    logic [CFG_DATA_W-1:0] v;
    int sel;
    drain();
    sel = $urandom_range(9);
    v = (sel == 0) ? '0 : (sel == 1) ? '1 : rand48();
    cfg_write(CFG_IF_MAC, v);
    v = rand48();
    v[0] = ($urandom_range(99) < 35);
    cfg_write(CFG_L3_ENABLED, v);
    sel = $urandom_range(9);
    v = rand48();
    v[1:0] = (sel == 0) ? L2_UNKNOWN : (sel == 1) ? L2_RESERVED :
             (sel < 6) ? L2_ACCESS : L2_TRUNK;
    cfg_write(CFG_L2_MODE, v);
    v = rand48();
    v[2:0] = 3'($urandom_range(7));
    cfg_write(CFG_VLAN_COUNT, v);
    for (int i = 0; i < HW_SLOTS; i++) begin
      sel = $urandom_range(9);
      v = rand48();
      if (sel == 0) v[VID_W-1:0] = '0;
      else if (sel == 1) v[VID_W-1:0] = '1;
      cfg_write(CFG_IDX_W'(CFG_VLAN_0 + i), v);
    end
    if ($urandom_range(3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_VLAN_0 + HW_SLOTS)),
                rand48());
    cfg_release();
  endtask

  initial begin : stimulus
    logic [MAC_W-1:0] mac_a;
    mac_a = 48'h02_00_5e_10_20_30;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // L3 mode, trunk settings left in place and ignored
    set_config(mac_a, 1'b1, L2_TRUNK, 3'd4, 12'd1, 12'd2, 12'd3, 12'd4);
    cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
    cfg_release();
    send_frame(mk(mac_a, ETYPE_VLAN, '1, '0, 16'd100));
    send_frame(mk('0, ETYPE_IPV4, '0, '0, 16'd100));
    send_frame(mk(mac_a, ETYPE_IPV4, '0, '0, '0));
    send_frame(mk(MAC_BCAST, ETYPE_IPV4, '0, '1, ETH_OVERHEAD));
    send_frame(mk(mac_a, ETYPE_IPV4, '1, '0, LEN_W'(ETH_OVERHEAD + 1)));
    send_frame(mk(mac_a, ETYPE_IPV4, '0, '0, '1));
    send_frame(mk(MAC_BCAST, ETYPE_ARP, '0, ARP_OP_REQUEST, 16'd60));
    send_frame(mk(mac_a, ETYPE_ARP, '0, ARP_OP_REPLY, 16'd60));
    send_frame(mk(mac_a, ETYPE_ARP, '0, '0, 16'd60));
    send_frame(mk(mac_a, ETYPE_ARP, '0, '1, 16'd60));
    send_frame(mk(mac_a, 16'h86dd, '0, '0, 16'd60));
    send_frame(mk(MAC_BCAST, '1, '0, '0, 16'd60));
    send_frame(mk(mac_a, '0, '0, '0, 16'd60));

    // access port without a VLAN
    set_config(mac_a, 1'b0, L2_ACCESS, 3'd0, '1, '0, '0, '0);
    send_frame(mk(mac_a, ETYPE_IPV4, '0, '0, 16'd64));
    send_frame(mk(mac_a, ETYPE_VLAN, 12'd7, '0, 16'd64));

    // access port, slot count above the limit
    set_config('1, 1'b0, L2_ACCESS, 3'd7, '1, 12'd5, 12'd6, 12'd7);
    send_frame(mk(rand48(), ETYPE_IPV4, '0, '0, 16'd64));
    send_frame(mk(MAC_BCAST, ETYPE_VLAN, '1, '0, 16'd64));

    // trunk port
    set_config(mac_a, 1'b0, L2_TRUNK, 3'd7, '0, '1, 12'd123, 12'd456);
    send_frame(mk(mac_a, ETYPE_VLAN, '0, '0, 16'd64));
    send_frame(mk(mac_a, ETYPE_VLAN, '1, '0, 16'd64));
    send_frame(mk(mac_a, ETYPE_VLAN, 12'd456, '0, 16'd64));
    send_frame(mk(mac_a, ETYPE_VLAN, 12'd789, '0, 16'd64));
    send_frame(mk(mac_a, ETYPE_IPV4, 12'd123, '0, 16'd64));

    // unknown L2 modes
    set_config(mac_a, 1'b0, L2_UNKNOWN, 3'd1, 12'd1, '0, '0, '0);
    send_frame(mk(mac_a, ETYPE_IPV4, '0, '0, 16'd64));
    set_config(mac_a, 1'b0, L2_RESERVED, 3'd1, 12'd1, '0, '0, '0);
    send_frame(mk(mac_a, ETYPE_VLAN, 12'd1, '0, 16'd64));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 9;
          rcv_idle_pct = 63;
        end
        1: begin
          snd_idle_pct = 63;
          rcv_idle_pct = 9;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        random_config();
        for (int k = 0; k < BLOCK_ITEMS; k++) begin
          send_frame(random_frame());
          if (ph == 2 && blk == 1 && k == 10) hold_reqs++;
          if (ph == 1 && blk == 2 && k == 20) drain();
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS l2_ingress_frame_classifier_core");
    end else begin
      $display("FAIL l2_ingress_frame_classifier_core");
    end
    $finish;
  end

endmodule
